/* rtl/uer_pkg.sv */
package uer_pkg;

    // Field and register widths.
    localparam int unsigned PERIOD_W    = 24;
    localparam int unsigned TRIG_W      = 8;
    localparam int unsigned WIDTH_W     = 20;
    localparam int unsigned RANGE_W     = 16;
    localparam int unsigned STATUS_W    = 2;
    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 24;

    // Register reset values.
    localparam logic                 ENABLE_RST    = 1'b1;
    localparam logic [PERIOD_W-1:0]  PERIOD_RST    = 24'd500000;
    localparam logic [TRIG_W-1:0]    TRIGGER_RST   = 8'd10;
    localparam logic [WIDTH_W-1:0]   TIMEOUT_RST   = 20'd100000;
    localparam logic [RANGE_W-1:0]   MIN_RANGE_RST = 16'd20;
    localparam logic [RANGE_W-1:0]   MAX_RANGE_RST = 16'd4000;

    // Distance is floor(width * 343 / 2000). The product is first divided by 16
    // with a shift, then by 125 through a multiply by ceil(2^32 / 125) and a
    // shift by 32, which is exact for every quotient input below 2^25.
    localparam int unsigned SPEED_NUM   = 343;
    localparam int unsigned PROD_W      = 29;
    localparam int unsigned PRE_SHIFT   = 4;
    localparam int unsigned SCALED_W    = PROD_W - PRE_SHIFT;
    localparam int unsigned RECIP_W     = 26;
    localparam int unsigned RECIP_SHIFT = 32;
    localparam int unsigned FULL_W      = SCALED_W + RECIP_W;
    localparam int unsigned QUOT_W      = 18;
    localparam logic [RECIP_W-1:0] RECIP_MUL = 26'd34359739;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ENABLE    = 3'd0,
        REG_PERIOD    = 3'd1,
        REG_TRIGGER   = 3'd2,
        REG_TIMEOUT   = 3'd3,
        REG_MIN_RANGE = 3'd4,
        REG_MAX_RANGE = 3'd5
    } reg_index_t;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_OK       = 2'd0,
        STATUS_NO_RISE  = 2'd1,
        STATUS_TOO_LONG = 2'd2,
        STATUS_RANGE    = 2'd3
    } status_t;

    typedef enum logic [3:0] {
        PH_IDLE = 4'b0001,
        PH_TRIG = 4'b0010,
        PH_WAIT = 4'b0100,
        PH_MEAS = 4'b1000
    } phase_t;

    typedef struct packed {
        logic                enable;
        logic [PERIOD_W-1:0] period_ticks;
        logic [TRIG_W-1:0]   trigger_ticks;
        logic [WIDTH_W-1:0]  timeout_ticks;
        logic [RANGE_W-1:0]  min_range_mm;
        logic [RANGE_W-1:0]  max_range_mm;
    } cfg_t;

    typedef struct packed {
        logic echo_level;
    } sample_t;

    // Result of the sequencer before the distance is worked out.
    typedef struct packed {
        logic                trig_level;
        logic                result_valid;
        logic [STATUS_W-1:0] status;
        logic [WIDTH_W-1:0]  echo_width;
    } raw_t;

    typedef struct packed {
        logic                trig_level;
        logic                result_valid;
        logic [STATUS_W-1:0] status;
        logic [RANGE_W-1:0]  distance_mm;
        logic [WIDTH_W-1:0]  echo_width;
    } result_t;

endpackage

/* rtl/uer_sample_if.sv */
interface uer_sample_if;
    logic             valid;
    logic             ready;
    uer_pkg::sample_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/uer_result_if.sv */
interface uer_result_if;
    logic             valid;
    logic             ready;
    uer_pkg::result_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

/* rtl/uer_cfg_regs.sv */
module uer_cfg_regs (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               cfg_wr_en,
    input  logic [uer_pkg::CFG_INDEX_W-1:0]    cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]     cfg_data,
    output uer_pkg::cfg_t                      cfg
);
    import uer_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr_en)
        begin
            unique case (reg_index_t'(cfg_index))
                REG_ENABLE:    cfg_next.enable        = cfg_data[0];
                REG_PERIOD:    cfg_next.period_ticks  = cfg_data[PERIOD_W-1:0];
                REG_TRIGGER:   cfg_next.trigger_ticks = cfg_data[TRIG_W-1:0];
                REG_TIMEOUT:   cfg_next.timeout_ticks = cfg_data[WIDTH_W-1:0];
                REG_MIN_RANGE: cfg_next.min_range_mm  = cfg_data[RANGE_W-1:0];
                REG_MAX_RANGE: cfg_next.max_range_mm  = cfg_data[RANGE_W-1:0];
                default:       cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.enable        <= ENABLE_RST;
            cfg_reg.period_ticks  <= PERIOD_RST;
            cfg_reg.trigger_ticks <= TRIGGER_RST;
            cfg_reg.timeout_ticks <= TIMEOUT_RST;
            cfg_reg.min_range_mm  <= MIN_RANGE_RST;
            cfg_reg.max_range_mm  <= MAX_RANGE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

/* rtl/uer_sequencer.sv */
module uer_sequencer (
    input  logic          clk,
    input  logic          rst_n,
    input  uer_pkg::cfg_t cfg,
    uer_sample_if.sink    sample,
    output uer_pkg::raw_t raw,
    output logic          raw_valid,
    input  logic          raw_ready
);
    import uer_pkg::*;

    phase_t               phase_reg;
    phase_t               phase_next;
    logic [PERIOD_W-1:0]  period_count_reg;
    logic [PERIOD_W-1:0]  period_count_next;
    logic [WIDTH_W-1:0]   phase_count_reg;
    logic [WIDTH_W-1:0]   phase_count_next;
    raw_t                 raw_reg;
    raw_t                 raw_next;
    logic                 raw_valid_reg;

    logic [PERIOD_W:0]    period_sum;
    logic [WIDTH_W-1:0]   phase_count_inc;
    logic [WIDTH_W-1:0]   trigger_len;
    logic                 accept;

    // The sequencer moves one tick per transfer; the raw register frees up
    // whenever the distance pipeline takes its content.
    assign sample.ready    = !raw_valid_reg || raw_ready;
    assign accept          = sample.valid && sample.ready;
    assign period_sum      = {1'b0, period_count_reg} + (PERIOD_W + 1)'(1);
    assign phase_count_inc = phase_count_reg + WIDTH_W'(1);
    assign trigger_len     = {{(WIDTH_W - TRIG_W){1'b0}}, cfg.trigger_ticks};

    always_comb
    begin
        phase_next        = phase_reg;
        period_count_next = period_count_reg;
        phase_count_next  = phase_count_reg;
        raw_next          = '0;
        raw_next.status   = STATUS_OK;

        if (!cfg.enable)
        begin
            phase_next        = PH_IDLE;
            period_count_next = '0;
            phase_count_next  = '0;
        end
        else
        begin
            if (period_sum >= {1'b0, cfg.period_ticks})
            begin
                period_count_next = '0;
            end
            else
            begin
                period_count_next = period_sum[PERIOD_W-1:0];
            end

            unique case (phase_reg)
                PH_IDLE:
                begin
                    if (period_count_reg == '0)
                    begin
                        phase_next          = PH_TRIG;
                        phase_count_next    = WIDTH_W'(1);
                        raw_next.trig_level = 1'b1;
                    end
                end
                PH_TRIG:
                begin
                    if (phase_count_reg < trigger_len)
                    begin
                        phase_count_next    = phase_count_inc;
                        raw_next.trig_level = 1'b1;
                    end
                    else
                    begin
                        phase_next       = PH_WAIT;
                        phase_count_next = '0;
                    end
                end
                PH_WAIT:
                begin
                    if (sample.data.echo_level)
                    begin
                        phase_next       = PH_MEAS;
                        phase_count_next = WIDTH_W'(1);
                    end
                    else if (phase_count_reg >= cfg.timeout_ticks)
                    begin
                        raw_next.result_valid = 1'b1;
                        raw_next.status       = STATUS_NO_RISE;
                        phase_next            = PH_IDLE;
                        phase_count_next      = '0;
                    end
                    else
                    begin
                        phase_count_next = phase_count_inc;
                    end
                end
                PH_MEAS:
                begin
                    if (sample.data.echo_level)
                    begin
                        if (phase_count_reg >= cfg.timeout_ticks)
                        begin
                            raw_next.result_valid = 1'b1;
                            raw_next.status       = STATUS_TOO_LONG;
                            raw_next.echo_width   = phase_count_reg;
                            phase_next            = PH_IDLE;
                            phase_count_next      = '0;
                        end
                        else
                        begin
                            phase_count_next = phase_count_inc;
                        end
                    end
                    else
                    begin
                        // Falling edge: the range check happens downstream.
                        raw_next.result_valid = 1'b1;
                        raw_next.status       = STATUS_OK;
                        raw_next.echo_width   = phase_count_reg;
                        phase_next            = PH_IDLE;
                        phase_count_next      = '0;
                    end
                end
                default:
                begin
                    phase_next       = PH_IDLE;
                    phase_count_next = '0;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            period_count_reg <= '0;
            phase_count_reg  <= '0;
            raw_valid_reg    <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg        <= phase_next;
                period_count_reg <= period_count_next;
                phase_count_reg  <= phase_count_next;
                raw_valid_reg    <= 1'b1;
            end
            else if (raw_ready)
            begin
                raw_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            raw_reg <= raw_next;
        end
    end

    assign raw       = raw_reg;
    assign raw_valid = raw_valid_reg;

endmodule

/* rtl/uer_distance.sv */
module uer_distance (
    input  logic          clk,
    input  logic          rst_n,
    input  uer_pkg::cfg_t cfg,
    input  uer_pkg::raw_t raw,
    input  logic          raw_valid,
    output logic          raw_ready,
    uer_result_if.source  result
);
    import uer_pkg::*;

    // Stage A: echo width times 343.
    logic                a_valid_reg;
    raw_t                a_raw_reg;
    logic [PROD_W-1:0]   a_prod_reg;
    logic                a_ready;
    logic [PROD_W-1:0]   a_prod_next;

    // Stage B: quotient by 2000.
    logic                b_valid_reg;
    raw_t                b_raw_reg;
    logic [QUOT_W-1:0]   b_quot_reg;
    logic                b_ready;
    logic [FULL_W-1:0]   recip_prod;

    // Output stage.
    logic                out_valid_reg;
    result_t             out_reg;
    result_t             out_next;
    logic                out_ready;
    logic                measured;

    assign out_ready = !out_valid_reg || result.ready;
    assign b_ready   = !b_valid_reg || out_ready;
    assign a_ready   = !a_valid_reg || b_ready;
    assign raw_ready = a_ready;

    assign a_prod_next = PROD_W'(raw.echo_width) * PROD_W'(SPEED_NUM);
    assign recip_prod  = FULL_W'(a_prod_reg[PROD_W-1:PRE_SHIFT]) * FULL_W'(RECIP_MUL);

    assign measured = b_raw_reg.result_valid && (b_raw_reg.status == STATUS_OK);

    always_comb
    begin
        out_next.trig_level   = b_raw_reg.trig_level;
        out_next.result_valid = b_raw_reg.result_valid;
        out_next.echo_width   = b_raw_reg.echo_width;
        out_next.status       = b_raw_reg.status;
        out_next.distance_mm  = '0;
        if (measured)
        begin
            if (b_quot_reg > QUOT_W'({RANGE_W{1'b1}}))
            begin
                out_next.distance_mm = {RANGE_W{1'b1}};
            end
            else
            begin
                out_next.distance_mm = b_quot_reg[RANGE_W-1:0];
            end
            // The range check looks at the quotient before saturation.
            if ((b_quot_reg > QUOT_W'(cfg.max_range_mm)) ||
                (b_quot_reg < QUOT_W'(cfg.min_range_mm)))
            begin
                out_next.status = STATUS_RANGE;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (a_ready)
            begin
                a_valid_reg <= raw_valid;
            end
            if (b_ready)
            begin
                b_valid_reg <= a_valid_reg;
            end
            if (out_ready)
            begin
                out_valid_reg <= b_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_ready && raw_valid)
        begin
            a_raw_reg  <= raw;
            a_prod_reg <= a_prod_next;
        end
        if (b_ready && a_valid_reg)
        begin
            b_raw_reg  <= a_raw_reg;
            b_quot_reg <= recip_prod[RECIP_SHIFT +: QUOT_W];
        end
        if (out_ready && b_valid_reg)
        begin
            out_reg <= out_next;
        end
    end

    assign result.valid = out_valid_reg;
    assign result.data  = out_reg;

endmodule

/* rtl/ultrasonic_echo_ranger.sv */
// Ultrasonic echo ranger.
// The sample channel carries one sampled echo level per microsecond tick, and
// every sample transfer yields exactly one transfer on the result channel: the
// trigger level to drive after that tick, plus a finished measurement when
// result_valid is set (status, distance in millimetres, echo width in ticks).
// The configuration port is a plain write port; write it only while no sample
// is in flight.
// A result is held in the sequencer register, the multiply by 343, the
// reciprocal multiply by 1/2000 and the output register, in that order, before
// it is offered. Throughput is one sample per cycle while the receiver keeps
// ready high; each pipeline stage holds its own valid bit, so a stalled result
// only stops the stages behind it once they have filled.
// Reset clears the sequencer to idle with the period counter at zero, empties
// the pipeline and loads the default register values, measurements enabled.
// When the receiver holds ready low, the result stays on the port unchanged and
// sample ready drops as soon as every stage in front of it is occupied.
module ultrasonic_echo_ranger (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [uer_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [uer_pkg::CFG_DATA_W-1:0]  cfg_data,
    uer_sample_if.sink                      sample,
    uer_result_if.source                    result
);
    import uer_pkg::*;

    cfg_t cfg;
    raw_t raw;
    logic raw_valid;
    logic raw_ready;

    uer_cfg_regs u_cfg_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    uer_sequencer u_sequencer (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .sample    (sample),
        .raw       (raw),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready)
    );

    uer_distance u_distance (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg),
        .raw       (raw),
        .raw_valid (raw_valid),
        .raw_ready (raw_ready),
        .result    (result)
    );

endmodule

/* rtl/uer_checker.sv */
module uer_checker (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         res_valid,
    input logic                         res_ready,
    input logic                         res_trig,
    input logic                         res_done,
    input logic [uer_pkg::STATUS_W-1:0] res_status,
    input logic [uer_pkg::RANGE_W-1:0]  res_distance,
    input logic [uer_pkg::WIDTH_W-1:0]  res_width
);
    import uer_pkg::*;

    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_ready |=> res_valid &&
            $stable({res_trig, res_done, res_status, res_distance, res_width}))
        else $error("result changed while stalled");

    a_idle_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && !res_done |->
            res_status == STATUS_OK && res_distance == '0 && res_width == '0)
        else $error("result fields set on a tick without a measurement");

    a_no_rise_empty: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done && res_status == STATUS_NO_RISE |->
            res_distance == '0 && res_width == '0)
        else $error("missing echo reported with a width or distance");

    a_too_long_width: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_done && res_status == STATUS_TOO_LONG |->
            res_distance == '0 && res_width != '0)
        else $error("overlong echo reported with a distance or no width");

    a_trig_not_done: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid |-> !(res_trig && res_done))
        else $error("trigger driven on the tick a measurement finished");

endmodule

bind ultrasonic_echo_ranger uer_checker u_uer_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (result.valid),
    .res_ready    (result.ready),
    .res_trig     (result.data.trig_level),
    .res_done     (result.data.result_valid),
    .res_status   (result.data.status),
    .res_distance (result.data.distance_mm),
    .res_width    (result.data.echo_width)
);

/* sim/tb.sv */
`timescale 1ns / 100ps

module tb;
    import uer_pkg::*;

    localparam int MM_NUM = 343;
    localparam int MM_DEN = 2000;
    localparam int WATCHDOG_LIMIT = 1000;
    localparam int SHOWN_MISMATCHES = 20;

    // Indexes past the last register; writes there must change nothing.
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

    typedef enum logic [1:0] {
        SEQ_IDLE,
        SEQ_TRIGGER,
        SEQ_WAIT_RISE,
        SEQ_MEASURE
    } seq_phase_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;

    uer_sample_if sample_ch();
    uer_result_if result_ch();

    ultrasonic_echo_ranger uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .sample    (sample_ch),
        .result    (result_ch)
    );

    always #2 clk = ~clk;

    // Register copies and sequencer state of the predictor.
    logic                m_enable;
    logic [PERIOD_W-1:0] m_period;
    logic [TRIG_W-1:0]   m_trigger;
    logic [WIDTH_W-1:0]  m_timeout;
    logic [RANGE_W-1:0]  m_min;
    logic [RANGE_W-1:0]  m_max;
    seq_phase_t          seq_phase;
    logic [PERIOD_W-1:0] per_count;
    logic [WIDTH_W-1:0]  ph_count;

    bit      echo_levels[$];
    result_t predicted_readings[$];
    int      samples_queued;
    int      samples_taken;
    int      readings_seen;
    int      mismatches;
    int      status_count[4];
    int      quiet_cycles;
    bit      hold_off;
    bit      calm;

    function automatic result_t range_tick(input logic echo);
        result_t        r;
        logic           start;
        logic [PERIOD_W:0] next_count;
        longint         distance;
        r = '0;
        if (!m_enable)
        begin
            seq_phase = SEQ_IDLE;
            per_count = '0;
            ph_count = '0;
        end
        else
        begin
            start = (per_count == '0);
            next_count = per_count + 1'b1;
            if (next_count >= m_period)
                next_count = '0;
            per_count = next_count[PERIOD_W-1:0];
            case (seq_phase)
                SEQ_IDLE:
                    if (start)
                    begin
                        seq_phase = SEQ_TRIGGER;
                        ph_count = WIDTH_W'(1);
                        r.trig_level = 1'b1;
                    end
                SEQ_TRIGGER:
                    if (ph_count < m_trigger)
                    begin
                        ph_count = ph_count + 1'b1;
                        r.trig_level = 1'b1;
                    end
                    else
                    begin
                        seq_phase = SEQ_WAIT_RISE;
                        ph_count = '0;
                    end
                SEQ_WAIT_RISE:
                    if (echo)
                    begin
                        seq_phase = SEQ_MEASURE;
                        ph_count = WIDTH_W'(1);
                    end
                    else if (ph_count >= m_timeout)
                    begin
                        r.result_valid = 1'b1;
                        r.status = STATUS_NO_RISE;
                        seq_phase = SEQ_IDLE;
                        ph_count = '0;
                    end
                    else
                        ph_count = ph_count + 1'b1;
                default:
                    if (echo)
                    begin
                        if (ph_count >= m_timeout)
                        begin
                            r.result_valid = 1'b1;
                            r.status = STATUS_TOO_LONG;
                            r.echo_width = ph_count;
                            seq_phase = SEQ_IDLE;
                            ph_count = '0;
                        end
                        else
                            ph_count = ph_count + 1'b1;
                    end
                    else
                    begin
                        // The range check sees the distance before saturation.
                        distance = (longint'(ph_count) * MM_NUM) / MM_DEN;
                        r.result_valid = 1'b1;
                        r.echo_width = ph_count;
                        r.distance_mm = (distance > 65535) ? '1 : distance[RANGE_W-1:0];
                        if (distance > longint'(m_max) || distance < longint'(m_min))
                            r.status = STATUS_RANGE;
                        else
                            r.status = STATUS_OK;
                        seq_phase = SEQ_IDLE;
                        ph_count = '0;
                    end
            endcase
        end
        return r;
    endfunction

    task automatic flag_mismatch(input string what, input int got, input int want);
        mismatches++;
        if (mismatches <= SHOWN_MISMATCHES)
            $display("mismatch in reading %0d: %s is %0d, expected %0d",
                     readings_seen, what, got, want);
    endtask

    task automatic push_levels(input bit level, input int n);
        repeat (n)
        begin
            echo_levels.push_back(level);
            samples_queued++;
        end
    endtask

    // Waits until every queued sample has transferred and every reading has come back.
    task automatic settle();
        while (samples_taken != samples_queued || predicted_readings.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            REG_ENABLE:    m_enable = value[0];
            REG_PERIOD:    m_period = value[PERIOD_W-1:0];
            REG_TRIGGER:   m_trigger = value[TRIG_W-1:0];
            REG_TIMEOUT:   m_timeout = value[WIDTH_W-1:0];
            REG_MIN_RANGE: m_min = value[RANGE_W-1:0];
            REG_MAX_RANGE: m_max = value[RANGE_W-1:0];
            default:       ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    // One setting drawn from the given ranges, then whole measurement periods:
    // mostly a trigger, a wait and one echo pulse, the rest random noise; only noise if period_max != 0.
    task automatic random_round(input int trig_max, input int tmo_lo, input int tmo_hi,
                                input int min_lo, input int min_hi, input int max_lo,
                                input int max_hi, input int period_max, input int count);
        int trig;
        int trig_eff;
        int tmo;
        int width_max;
        int span;
        int lead;
        int width;
        int start_count;
        settle();
        trig = $urandom_range(trig_max, 0);
        trig_eff = (trig == 0) ? 1 : trig;
        tmo = $urandom_range(tmo_hi, tmo_lo);
        width_max = (tmo == 0) ? 1 : tmo;
        if (period_max != 0)
            span = $urandom_range(period_max, 0);
        else
            span = trig_eff + 2 * tmo + 6 + $urandom_range(8, 0);
        write_reg(REG_PERIOD, CFG_DATA_W'(span));
        // Junk in the bits above the trigger and timeout fields must be dropped.
        write_reg(REG_TRIGGER, {16'($urandom), 8'(trig)});
        write_reg(REG_TIMEOUT, {4'($urandom), 20'(tmo)});
        write_reg(REG_MIN_RANGE, CFG_DATA_W'($urandom_range(min_hi, min_lo)));
        write_reg(REG_MAX_RANGE, CFG_DATA_W'($urandom_range(max_hi, max_lo)));
        start_count = samples_queued;
        while (samples_queued - start_count < count)
        begin
            if (period_max != 0 || $urandom_range(99, 0) < 15)
            begin
                repeat ((span < 4) ? 8 : span)
                    push_levels(1'($urandom_range(1, 0)), 1);
            end
            else
            begin
                lead = ($urandom_range(9, 0) == 0) ? tmo + 1 + $urandom_range(2, 0)
                                                   : $urandom_range(tmo, 0);
                width = ($urandom_range(9, 0) == 0) ? width_max + 1 + $urandom_range(2, 0)
                                                    : $urandom_range(width_max, 1);
                push_levels(1'b0, trig_eff + 1 + lead);
                push_levels(1'b1, width);
                push_levels(1'b0, (span > trig_eff + 2 + lead + width) ?
                                  span - (trig_eff + 1 + lead + width) : 1);
            end
        end
    endtask

    // Sample driver.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_ch.valid <= 1'b0;
            sample_ch.data <= '0;
        end
        else
        begin
            if (sample_ch.valid && sample_ch.ready)
            begin
                predicted_readings.push_back(range_tick(sample_ch.data.echo_level));
                samples_taken++;
            end
            if (!sample_ch.valid || sample_ch.ready)
            begin
                if (echo_levels.size() != 0 && !hold_off && (calm || $urandom_range(99, 0) >= 12))
                begin
                    sample_ch.valid <= 1'b1;
                    sample_ch.data.echo_level <= echo_levels.pop_front();
                end
                else
                    sample_ch.valid <= 1'b0;
            end
        end
    end

    // Reading monitor.
    always @(posedge clk or negedge rst_n)
    begin : reading_check
        result_t got;
        result_t want;
        if (!rst_n)
            result_ch.ready <= 1'b0;
        else
        begin
            if (result_ch.valid && result_ch.ready)
            begin
                readings_seen++;
                got = result_ch.data;
                if (predicted_readings.size() == 0)
                    flag_mismatch("reading with no sample behind it", 1, 0);
                else
                begin
                    want = predicted_readings.pop_front();
                    if (got.trig_level !== want.trig_level)
                        flag_mismatch("trig_level", got.trig_level, want.trig_level);
                    if (got.result_valid !== want.result_valid)
                        flag_mismatch("result_valid", got.result_valid, want.result_valid);
                    if (got.status !== want.status)
                        flag_mismatch("status", got.status, want.status);
                    if (got.distance_mm !== want.distance_mm)
                        flag_mismatch("distance_mm", got.distance_mm, want.distance_mm);
                    if (got.echo_width !== want.echo_width)
                        flag_mismatch("echo_width", got.echo_width, want.echo_width);
                    if (want.result_valid)
                        status_count[want.status]++;
                end
            end
            result_ch.ready <= calm || ($urandom_range(99, 0) >= 12);
        end
    end

    always @(posedge clk)
    begin
        if ((sample_ch.valid && sample_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= WATCHDOG_LIMIT)
        begin
            $display("watchdog: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("tb: errors");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial
    begin
        rst_n = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_ENABLE;
        cfg_data = '0;
        m_enable = ENABLE_RST;
        m_period = PERIOD_RST;
        m_trigger = TRIGGER_RST;
        m_timeout = TIMEOUT_RST;
        m_min = MIN_RANGE_RST;
        m_max = MAX_RANGE_RST;
        seq_phase = SEQ_IDLE;
        per_count = '0;
        ph_count = '0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Default setting: a full trigger pulse, then the echo rises and is cut off
        // by disabling, which aborts the measurement.
        push_levels(1'b0, 11);
        push_levels(1'b1, 1);
        settle();
        write_reg(REG_ENABLE, 24'h000000);
        push_levels(1'b1, 2);
        settle();

        // All-zero registers: a start whenever the sequencer is idle, the shortest trigger and timeout.
        write_reg(REG_PERIOD, 24'h000000);
        write_reg(REG_TRIGGER, 24'h000000);
        write_reg(REG_TIMEOUT, 24'h000000);
        write_reg(REG_MIN_RANGE, 24'h000000);
        write_reg(REG_MAX_RANGE, 24'h000000);
        write_reg(REG_SPARE_A, 24'hFFFFFF);
        write_reg(REG_SPARE_B, 24'h5A5A5A);
        write_reg(REG_ENABLE, 24'h000001);
        push_levels(1'b0, 3);   // no echo rise
        push_levels(1'b0, 2);
        push_levels(1'b1, 1);
        push_levels(1'b0, 1);   // one-tick echo, zero distance
        push_levels(1'b0, 2);
        push_levels(1'b1, 2);   // echo too long

        random_round(3, 3, 10, 0, 1, 1, 3, 0, 50);

        random_round(6, 20, 60, 0, 4, 4, 12, 0, 50);
        while (echo_levels.size() > 25)
            @(posedge clk);
        hold_off <= 1'b1;
        do
            @(posedge clk);
        while (sample_ch.valid || predicted_readings.size() != 0);
        hold_off <= 1'b0;

        // Minimum above maximum, run without any idling.
        calm <= 1'b1;
        random_round(4, 10, 30, 6, 12, 0, 5, 0, 50);
        settle();
        calm <= 1'b0;

        write_reg(REG_ENABLE, 24'hFFFFFE);
        write_reg(REG_ENABLE, 24'h800001);
        random_round(8, 1, 1, 0, 0, 65535, 65535, 0, 50);

        // Tiny periods after long ones: the period counter has to wrap early.
        random_round(2, 0, 3, 0, 1, 0, 2, 3, 50);

        // Longest trigger pulse, with every distance below the minimum.
        settle();
        write_reg(REG_ENABLE, 24'h000000);
        write_reg(REG_PERIOD, CFG_DATA_W'(300));
        write_reg(REG_TRIGGER, CFG_DATA_W'(255));
        write_reg(REG_TIMEOUT, CFG_DATA_W'(20));
        write_reg(REG_MIN_RANGE, CFG_DATA_W'(65535));
        write_reg(REG_MAX_RANGE, CFG_DATA_W'(65535));
        write_reg(REG_ENABLE, 24'h000001);
        push_levels(1'b0, 258);
        push_levels(1'b1, 8);
        push_levels(1'b0, 6);

        settle();
        $display("run: %0d echo samples, %0d readings checked", samples_taken, readings_seen);
        $display("run: measurements ok %0d, no rise %0d, too long %0d, out of range %0d",
                 status_count[STATUS_OK], status_count[STATUS_NO_RISE],
                 status_count[STATUS_TOO_LONG], status_count[STATUS_RANGE]);
        if (mismatches == 0)
            $display("tb: clean");
        else
            $display("tb: errors");
        $finish;
    end
endmodule
